/* rtl/core/lced_pkg.sv */
// shared types and constants of the line centroid edge detector
// depends on nothing; used by lced_front, lced_back and the top level
package lced_pkg;

  // register map, index of each register in the config space
  localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_HUE_THRESHOLD  = 3'd2;
  localparam logic [2:0] REG_GRAY_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_STRIP_WIDTH    = 3'd4;
  localparam logic [2:0] REG_EDGE_MIN_COUNT = 3'd5;
  localparam logic [2:0] REG_OFFSET_LOW     = 3'd6;
  localparam logic [2:0] REG_OFFSET_HIGH    = 3'd7;

  localparam logic [10:0] RST_FRAME_WIDTH    = 11'd640;
  localparam logic [10:0] RST_FRAME_HEIGHT   = 11'd480;
  localparam logic [7:0]  RST_HUE_THRESHOLD  = 8'd20;
  localparam logic [7:0]  RST_GRAY_THRESHOLD = 8'd200;
  localparam logic [9:0]  RST_STRIP_WIDTH    = 10'd40;
  localparam logic [20:0] RST_EDGE_MIN_COUNT = 21'd5000;
  localparam logic [9:0]  RST_OFFSET_LOW     = 10'd230;
  localparam logic [9:0]  RST_OFFSET_HIGH    = 10'd250;

  typedef enum logic [1:0] {
    EDGE_NONE  = 2'd0,
    EDGE_LEFT  = 2'd1,
    EDGE_RIGHT = 2'd2
  } edge_e;

  typedef enum logic [2:0] {
    CORR_NONE      = 3'd0,
    CORR_LEFT      = 3'd1,
    CORR_RIGHT     = 3'd2,
    CORR_ROT_RIGHT = 3'd3,
    CORR_ROT_LEFT  = 3'd4
  } corr_e;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic [7:0]  hue_threshold;
    logic [7:0]  gray_threshold;
    logic [9:0]  strip_width;
    logic [20:0] edge_min_count;
    logic [9:0]  offset_low;
    logic [9:0]  offset_high;
  } cfg_t;

  typedef struct packed {
    edge_e       edge_flag;
    corr_e       correction;
    logic [9:0]  centroid_x;
    logic [9:0]  centroid_y;
    logic        centroid_valid;
    logic [13:0] left_row;
    logic [13:0] right_row;
    logic        strips_valid;
    logic        offset_flag;
    logic        rotate_right;
    logic        rotate_left;
  } res_t;

endpackage

/* rtl/core/lced_pix_if.sv */
// pixel channel: valid/ready handshake with gray and hue payload
// depends on nothing
interface lced_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] gray_level;
  logic [7:0] hue_level;

  modport source (output valid, output gray_level, output hue_level, input ready);
  modport sink   (input valid, input gray_level, input hue_level, output ready);
endinterface

/* rtl/core/lced_res_if.sv */
// result channel: valid/ready handshake with one frame summary as payload
// depends on nothing
interface lced_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  edge_flag;
  logic [2:0]  correction;
  logic [9:0]  centroid_x;
  logic [9:0]  centroid_y;
  logic        centroid_valid;
  logic [13:0] left_row;
  logic [13:0] right_row;
  logic        strips_valid;
  logic        offset_flag;
  logic        rotate_right;
  logic        rotate_left;

  modport source (output valid, output edge_flag, output correction, output centroid_x,
                  output centroid_y, output centroid_valid, output left_row,
                  output right_row, output strips_valid, output offset_flag,
                  output rotate_right, output rotate_left, input ready);
  modport sink   (input valid, input edge_flag, input correction, input centroid_x,
                  input centroid_y, input centroid_valid, input left_row,
                  input right_row, input strips_valid, input offset_flag,
                  input rotate_right, input rotate_left, output ready);
endinterface

/* rtl/core/lced_front.sv */
// pixel front end: position counters and per-frame accumulators
// depends on lced_pkg and lced_pix_if
module lced_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int RW  = $clog2(MAX_HEIGHT),
  localparam int NW  = CW + RW + 1,
  localparam int XSW = NW + CW,
  localparam int YSW = NW + RW,
  localparam int SNW = 5 * NW + XSW + 3 * YSW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lced_pkg::cfg_t    cfg_i,
  lced_pix_if.sink          pix,
  output logic              push_valid_o,
  output logic [SNW-1:0]    push_data_o,
  input  logic              push_ready_i
);

  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [NW-1:0]  n_q, n_d, lc_q, lc_d, rc_q, rc_d, lb_q, lb_d, rb_q, rb_d;
  logic [XSW-1:0] sx_q, sx_d;
  logic [YSW-1:0] sy_q, sy_d, ly_q, ly_d, ry_q, ry_d;
  logic [15:0]    w, h;
  logic           last_col, last_row, in_right, left_b, left_l;
  logic           bright, line, accept, last;

  assign pix.ready = push_ready_i;
  assign accept    = pix.valid && pix.ready;

  always_comb begin
    // zero size acts as one, oversize saturates
    if (cfg_i.frame_width == 11'd0) w = 16'd1;
    else if (16'(cfg_i.frame_width) > 16'(MAX_WIDTH)) w = 16'(MAX_WIDTH);
    else w = 16'(cfg_i.frame_width);
    if (cfg_i.frame_height == 11'd0) h = 16'd1;
    else if (16'(cfg_i.frame_height) > 16'(MAX_HEIGHT)) h = 16'(MAX_HEIGHT);
    else h = 16'(cfg_i.frame_height);
  end

  assign last_col = 16'(col_q) >= w - 16'd1;
  assign last_row = 16'(row_q) >= h - 16'd1;
  assign last     = last_col && last_row;
  assign in_right = (17'(col_q) + 17'(cfg_i.strip_width)) >= 17'(w);
  assign left_b   = 16'(col_q) <= 16'(cfg_i.strip_width);
  assign left_l   = 16'(col_q) < 16'(cfg_i.strip_width);
  assign bright   = pix.gray_level > cfg_i.gray_threshold;
  assign line     = pix.hue_level <= cfg_i.hue_threshold;

  always_comb begin
    n_d  = n_q + NW'(line);
    sx_d = line ? sx_q + XSW'(col_q) : sx_q;
    sy_d = line ? sy_q + YSW'(row_q) : sy_q;
    lc_d = lc_q + NW'(line && left_l);
    ly_d = (line && left_l) ? ly_q + YSW'(row_q) : ly_q;
    rc_d = rc_q + NW'(line && in_right);
    ry_d = (line && in_right) ? ry_q + YSW'(row_q) : ry_q;
    lb_d = lb_q + NW'(bright && left_b);
    rb_d = rb_q + NW'(bright && !left_b && in_right);
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + RW'(1);
    end else begin
      col_d = col_q + CW'(1);
      row_d = row_q;
    end
  end

  assign push_valid_o = accept && last;
  assign push_data_o  = {n_d, sx_d, sy_d, lc_d, ly_d, rc_d, ry_d, lb_d, rb_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; row_q <= '0;
      n_q <= '0; sx_q <= '0; sy_q <= '0;
      lc_q <= '0; ly_q <= '0; rc_q <= '0; ry_q <= '0;
      lb_q <= '0; rb_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      if (last) begin
        n_q <= '0; sx_q <= '0; sy_q <= '0;
        lc_q <= '0; ly_q <= '0; rc_q <= '0; ry_q <= '0;
        lb_q <= '0; rb_q <= '0;
      end else begin
        n_q <= n_d; sx_q <= sx_d; sy_q <= sy_d;
        lc_q <= lc_d; ly_q <= ly_d; rc_q <= rc_d; ry_q <= ry_d;
        lb_q <= lb_d; rb_q <= rb_d;
      end
    end
  end

endmodule

/* rtl/core/lced_fifo.sv */
// two-entry queue carrying frame sums from front end to back end
// depends on nothing
module lced_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o,
  input  logic             pop_ready_i
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

  assign pop_data_o = mem_q[rd_q];

endmodule

/* rtl/core/lced_back.sv */
// frame back end: bit-serial dividers and multipliers, result register
// depends on lced_pkg and lced_res_if
module lced_back #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_HEIGHT   = 1024,
  parameter int SLANT_MARGIN = 15,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int RW  = $clog2(MAX_HEIGHT),
  localparam int NW  = CW + RW + 1,
  localparam int XSW = NW + CW,
  localparam int YSW = NW + RW,
  localparam int SNW = 5 * NW + XSW + 3 * YSW,
  localparam int MXW = (CW > RW) ? CW : RW,
  localparam int DW  = NW + MXW + 4,
  localparam int PW  = 2 * NW + RW + 9,
  localparam int CNW = $clog2(DW + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lced_pkg::cfg_t cfg_i,
  input  logic           pop_valid_i,
  input  logic [SNW-1:0] pop_data_i,
  output logic           pop_ready_o,
  lced_res_if.source     res
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic           state_q;
  logic [CNW-1:0] cnt_q;
  logic [DW-1:0]  num_q [4];
  logic [DW-1:0]  num_nx [4];
  logic [NW-1:0]  rem_q [4];
  logic [NW-1:0]  rem_nx [4];
  logic [NW-1:0]  den_q [4];
  logic [NW:0]    trial [4];
  logic [PW-1:0]  mc_q [3];
  logic [NW-1:0]  mb_q [3];
  logic [PW-1:0]  acc_q [3];
  logic [PW-1:0]  acc_nx [3];
  logic [NW-1:0]  n_q, lc_q, rc_q, lb_q, rb_q;

  logic [NW-1:0]  n_w, lc_w, rc_w, lb_w, rb_w;
  logic [XSW-1:0] sx_w;
  logic [YSW-1:0] sy_w, ly_w, ry_w;
  logic [NW+7:0]  lcm_w;

  logic            res_valid_q;
  lced_pkg::res_t  res_q, res_d;
  logic            start, finish, store, cval, sval, ror, rol;

  assign {n_w, sx_w, sy_w, lc_w, ly_w, rc_w, ry_w, lb_w, rb_w} = pop_data_i;
  assign lcm_w = (NW + 8)'(lc_w) * (NW + 8)'(SLANT_MARGIN);

  assign pop_ready_o = state_q == ST_IDLE;
  assign start  = pop_valid_i && pop_ready_o;
  assign finish = (state_q == ST_RUN) && (cnt_q == CNW'(DW));
  assign store  = finish && (!res_valid_q || res.ready);

  // one restoring-division step per lane, one shift-add step per product
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      trial[i] = {rem_q[i], num_q[i][DW-1]};
      if (trial[i] >= {1'b0, den_q[i]}) begin
        rem_nx[i] = NW'(trial[i] - {1'b0, den_q[i]});
        num_nx[i] = {num_q[i][DW-2:0], 1'b1};
      end else begin
        rem_nx[i] = trial[i][NW-1:0];
        num_nx[i] = {num_q[i][DW-2:0], 1'b0};
      end
    end
    for (int j = 0; j < 3; j++) begin
      acc_nx[j] = mb_q[j][0] ? acc_q[j] + mc_q[j] : acc_q[j];
    end
  end

  assign cval = n_q != '0;
  assign sval = (lc_q != '0) && (rc_q != '0);
  // acc 0: left sum times right count, acc 1: right sum times left count,
  // acc 2: margin times both counts
  assign ror  = sval && (acc_q[1] > acc_q[0] + acc_q[2]);
  assign rol  = sval && !ror && (acc_q[0] > acc_q[1] + acc_q[2]);

  always_comb begin
    res_d = '0;
    if (32'(lb_q) > 32'(cfg_i.edge_min_count) && lb_q > rb_q) begin
      res_d.edge_flag = lced_pkg::EDGE_LEFT;
    end else if (32'(rb_q) > 32'(cfg_i.edge_min_count) && rb_q > lb_q) begin
      res_d.edge_flag = lced_pkg::EDGE_RIGHT;
    end else begin
      res_d.edge_flag = lced_pkg::EDGE_NONE;
    end
    priority if (res_d.edge_flag == lced_pkg::EDGE_LEFT) res_d.correction = lced_pkg::CORR_LEFT;
    else if (res_d.edge_flag == lced_pkg::EDGE_RIGHT) res_d.correction = lced_pkg::CORR_RIGHT;
    else if (ror) res_d.correction = lced_pkg::CORR_ROT_RIGHT;
    else if (rol) res_d.correction = lced_pkg::CORR_ROT_LEFT;
    else res_d.correction = lced_pkg::CORR_NONE;
    res_d.centroid_valid = cval;
    res_d.strips_valid   = sval;
    res_d.rotate_right   = ror;
    res_d.rotate_left    = rol;
    if (cval) begin
      res_d.centroid_x  = num_q[0][9:0];
      res_d.centroid_y  = num_q[1][9:0];
      res_d.offset_flag = (num_q[1] < DW'(cfg_i.offset_low)) ||
                          (num_q[1] > DW'(cfg_i.offset_high));
    end
    if (sval) begin
      res_d.left_row  = num_q[2][13:0];
      res_d.right_row = num_q[3][13:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (res.valid && res.ready) res_valid_q <= 1'b0;
      if (store) res_valid_q <= 1'b1;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_RUN;
            cnt_q   <= '0;
          end
        end
        ST_RUN: begin
          if (store) state_q <= ST_IDLE;
          else if (!finish) cnt_q <= cnt_q + CNW'(1);
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      num_q[0] <= DW'(sx_w);
      num_q[1] <= DW'(sy_w);
      num_q[2] <= DW'({ly_w, 4'b0000});
      num_q[3] <= DW'({ry_w, 4'b0000});
      den_q[0] <= n_w;
      den_q[1] <= n_w;
      den_q[2] <= lc_w;
      den_q[3] <= rc_w;
      for (int i = 0; i < 4; i++) rem_q[i] <= '0;
      mc_q[0] <= PW'(ly_w);
      mc_q[1] <= PW'(ry_w);
      mc_q[2] <= PW'(lcm_w);
      mb_q[0] <= rc_w;
      mb_q[1] <= lc_w;
      mb_q[2] <= rc_w;
      for (int j = 0; j < 3; j++) acc_q[j] <= '0;
      n_q  <= n_w;
      lc_q <= lc_w;
      rc_q <= rc_w;
      lb_q <= lb_w;
      rb_q <= rb_w;
    end else if (state_q == ST_RUN && !finish) begin
      for (int i = 0; i < 4; i++) begin
        num_q[i] <= num_nx[i];
        rem_q[i] <= rem_nx[i];
      end
      for (int j = 0; j < 3; j++) begin
        acc_q[j] <= acc_nx[j];
        mc_q[j]  <= mc_q[j] << 1;
        mb_q[j]  <= mb_q[j] >> 1;
      end
    end
    if (store) res_q <= res_d;
  end

  assign res.valid          = res_valid_q;
  assign res.edge_flag      = res_q.edge_flag;
  assign res.correction     = res_q.correction;
  assign res.centroid_x     = res_q.centroid_x;
  assign res.centroid_y     = res_q.centroid_y;
  assign res.centroid_valid = res_q.centroid_valid;
  assign res.left_row       = res_q.left_row;
  assign res.right_row      = res_q.right_row;
  assign res.strips_valid   = res_q.strips_valid;
  assign res.offset_flag    = res_q.offset_flag;
  assign res.rotate_right   = res_q.rotate_right;
  assign res.rotate_left    = res_q.rotate_left;

`ifndef SYNTHESIS
  a_no_rot_without_strips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store && !sval |-> !ror && !rol) else $error("rotate flag with empty strip");
  a_store_only_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store |-> $past(state_q) == ST_RUN) else $error("result stored outside run");
  a_no_start_while_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> !pop_ready_o) else $error("queue popped during run");
`endif

endmodule

/* rtl/core/line_centroid_edge_detector.sv */
// top level of the line centroid edge detector: config registers and wiring
// depends on lced_pkg, lced_pix_if, lced_res_if, lced_front, lced_fifo, lced_back
//
// takes one pixel per clock (gray and hue) in raster order and, after the last
// pixel of each frame, issues one result transaction with the edge flag,
// correction code, floored line centroid, strip rows in q10.4 and the
// offset and rotate flags. the front end accepts a pixel every cycle as long
// as the two-entry frame queue has room; the back end runs bit-serial
// restoring dividers and shift-add multipliers, one bit per cycle, producing
// DW-bit quotients, with DW = clog2(MAX_WIDTH) + clog2(MAX_HEIGHT) + 1 + the
// larger of the two + 4 (35 at the defaults), and takes a new frame only
// once the last result is stored. frames shorter than the back end's run fill
// the queue and stall pixel input.
// config registers sit at byte address 4*index and must be written while idle.
module line_centroid_edge_detector #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_HEIGHT   = 1024,
  parameter int SLANT_MARGIN = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  lced_pix_if.sink    pix_i,
  lced_res_if.source  res_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int NW  = CW + RW + 1;
  localparam int SNW = 5 * NW + (NW + CW) + 3 * (NW + RW);

  lced_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic           push_valid, push_ready, pop_valid, pop_ready;
  logic [SNW-1:0] push_data, pop_data;

  // config port, pready tied high so no wait states
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= lced_pkg::RST_FRAME_WIDTH;
      cfg_q.frame_height   <= lced_pkg::RST_FRAME_HEIGHT;
      cfg_q.hue_threshold  <= lced_pkg::RST_HUE_THRESHOLD;
      cfg_q.gray_threshold <= lced_pkg::RST_GRAY_THRESHOLD;
      cfg_q.strip_width    <= lced_pkg::RST_STRIP_WIDTH;
      cfg_q.edge_min_count <= lced_pkg::RST_EDGE_MIN_COUNT;
      cfg_q.offset_low     <= lced_pkg::RST_OFFSET_LOW;
      cfg_q.offset_high    <= lced_pkg::RST_OFFSET_HIGH;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        lced_pkg::REG_FRAME_WIDTH:    cfg_q.frame_width    <= pwdata[10:0];
        lced_pkg::REG_FRAME_HEIGHT:   cfg_q.frame_height   <= pwdata[10:0];
        lced_pkg::REG_HUE_THRESHOLD:  cfg_q.hue_threshold  <= pwdata[7:0];
        lced_pkg::REG_GRAY_THRESHOLD: cfg_q.gray_threshold <= pwdata[7:0];
        lced_pkg::REG_STRIP_WIDTH:    cfg_q.strip_width    <= pwdata[9:0];
        lced_pkg::REG_EDGE_MIN_COUNT: cfg_q.edge_min_count <= pwdata[20:0];
        lced_pkg::REG_OFFSET_LOW:     cfg_q.offset_low     <= pwdata[9:0];
        lced_pkg::REG_OFFSET_HIGH:    cfg_q.offset_high    <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[4:2])
      lced_pkg::REG_FRAME_WIDTH:    prdata = 32'(cfg_q.frame_width);
      lced_pkg::REG_FRAME_HEIGHT:   prdata = 32'(cfg_q.frame_height);
      lced_pkg::REG_HUE_THRESHOLD:  prdata = 32'(cfg_q.hue_threshold);
      lced_pkg::REG_GRAY_THRESHOLD: prdata = 32'(cfg_q.gray_threshold);
      lced_pkg::REG_STRIP_WIDTH:    prdata = 32'(cfg_q.strip_width);
      lced_pkg::REG_EDGE_MIN_COUNT: prdata = 32'(cfg_q.edge_min_count);
      lced_pkg::REG_OFFSET_LOW:     prdata = 32'(cfg_q.offset_low);
      lced_pkg::REG_OFFSET_HIGH:    prdata = 32'(cfg_q.offset_high);
      default:                      prdata = '0;
    endcase
  end

  // front end: counters and accumulators, hands a frame's sums to the queue
  lced_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pix          (pix_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  // decouples pixel intake from the end-of-frame arithmetic
  lced_fifo #(
    .WIDTH (SNW)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  // back end: divisions, slant cross products, result register
  lced_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .SLANT_MARGIN (SLANT_MARGIN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .res         (res_o)
  );

`ifndef SYNTHESIS
  a_edge_left_corr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.edge_flag == lced_pkg::EDGE_LEFT |->
      res_o.correction == lced_pkg::CORR_LEFT) else $error("left edge without left correction");
  a_no_centroid_no_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.centroid_valid |-> !res_o.offset_flag && res_o.centroid_x == 10'd0)
    else $error("offset or centroid without line pixels");
  a_rotate_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.rotate_right && res_o.rotate_left))
    else $error("both rotate flags set");
`endif

endmodule
